/* design/ssr_pkg.sv */
`default_nettype none
package ssr_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_WINDOW_DEF = 16;

    // stored per-column sums
    localparam int SUM_W = 16;
    localparam int SQ_W  = 24;

    // fraction bits of the SSIM values and width of a result word
    localparam int Q_FRAC = 30;
    localparam int RES_W  = Q_FRAC + 2;

    // scaled stabilizers: 2/C1 with C1 = 1e-4, 1/C1, and C2/C1
    localparam int LUM_K = 20000;
    localparam int VAR_K = 10000;
    localparam int ST_K  = 9;

    typedef struct packed {
        logic [SUM_W-1:0] sa;
        logic [SUM_W-1:0] sb;
        logic [SQ_W-1:0]  saa;
        logic [SQ_W-1:0]  sbb;
        logic [SQ_W-1:0]  sab;
    } t_sums;

endpackage
`default_nettype wire

/* design/ssr_div.sv */
`default_nettype none
module ssr_div #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic             r_done;

    logic [DEN_W:0]   t_val;
    logic             t_ge;
    logic [DEN_W:0]   t_sub;

    always_comb begin
        t_val = {r_rem, r_quo[NUM_W-1]};
        t_ge  = (t_val >= {1'b0, r_den});
        t_sub = t_val - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_rem   <= '0;
                        r_quo   <= i_num;
                        r_den   <= i_den;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    // shift in one dividend bit, subtract when it fits
                    r_rem <= t_ge ? t_sub[DEN_W-1:0] : t_val[DEN_W-1:0];
                    r_quo <= {r_quo[NUM_W-2:0], t_ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(NUM_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

/* design/ssr_win.sv */
`default_nettype none
module ssr_win #(
    parameter int N_W = 9
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [N_W-1:0]                     i_n,
    input  ssr_pkg::t_sums                     i_sums,
    output logic                               o_done,
    output logic signed [ssr_pkg::RES_W-1:0]   o_res
);

    localparam int P_W   = 2 * ssr_pkg::SUM_W;
    localparam int Q_W   = N_W + ssr_pkg::SQ_W;
    localparam int M_W   = (Q_W > P_W) ? Q_W : P_W;
    localparam int COV_W = M_W + 1;
    localparam int VAR_W = M_W + 2;
    localparam int N2_W  = 2 * N_W;
    localparam int L_W   = P_W + 16;
    localparam int SN_W  = COV_W + 16;
    localparam int SD_W  = VAR_W + 15;
    localparam int X_W   = (SN_W > SD_W) ? SN_W : SD_W;
    localparam int D_W   = (L_W > SD_W) ? L_W : SD_W;
    localparam int QS_W  = ssr_pkg::Q_FRAC + 2;
    localparam int QR_W  = ssr_pkg::Q_FRAC + 1;
    localparam int PR_W  = 2 * QR_W;
    localparam int CNT_W = $clog2(QS_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_MUL2,
        S_PREP,
        S_DIV,
        S_PROD,
        S_RND
    } t_state;

    t_state                    r_state;
    logic [P_W-1:0]            r_pab, r_paa, r_pbb;
    logic [Q_W-1:0]            r_qab, r_qaa, r_qbb;
    logic [N2_W-1:0]           r_n2;
    logic signed [COV_W-1:0]   r_cov;
    logic signed [VAR_W-1:0]   r_var;
    logic [P_W:0]              r_lsq;
    logic [L_W-1:0]            r_lnum, r_lden;
    logic signed [SN_W-1:0]    r_snum;
    logic [SD_W-1:0]           r_sden;
    logic                      r_neg;
    logic [SD_W-1:0]           r_smag;
    logic [D_W:0]              r_dr;
    logic [D_W-1:0]            r_dd;
    logic [QS_W-1:0]           r_dq;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_phase;
    logic [QR_W-1:0]           r_lum, r_st;
    logic [PR_W-1:0]           r_prod;
    logic                      r_done;
    logic signed [ssr_pkg::RES_W-1:0] r_res;

    logic [N2_W+3:0]           n2x9;
    logic [VAR_W-2:0]          v_pos;
    logic                      s_neg;
    logic [SN_W-1:0]           s_mag;
    logic [SD_W-1:0]           s_clamp;
    logic [D_W:0]              d_t;
    logic                      d_ge;
    logic [D_W:0]              d_rem;
    logic [QS_W-1:0]           d_q;
    logic [QS_W:0]             d_rnd;
    logic [PR_W:0]             p_sum;
    logic [QR_W-1:0]           p_mag;

    always_comb begin
        n2x9    = (N2_W+4)'({r_n2, 3'b000}) + (N2_W+4)'(r_n2);
        v_pos   = r_var[VAR_W-1] ? '0 : r_var[VAR_W-2:0];
        s_neg   = r_snum[SN_W-1];
        s_mag   = s_neg ? SN_W'(-r_snum) : SN_W'(r_snum);
        s_clamp = (X_W'(s_mag) > X_W'(r_sden)) ? r_sden : SD_W'(s_mag);
        // first step compares the numerator itself, later steps double the remainder
        d_t     = (r_cnt == '0) ? r_dr : {r_dr[D_W-1:0], 1'b0};
        d_ge    = (d_t >= {1'b0, r_dd});
        d_rem   = d_ge ? (d_t - {1'b0, r_dd}) : d_t;
        d_q     = {r_dq[QS_W-2:0], d_ge};
        d_rnd   = (QS_W+1)'(d_q) + (QS_W+1)'(1);
        p_sum   = (PR_W+1)'(r_prod) + ((PR_W+1)'(1) << (ssr_pkg::Q_FRAC - 1));
        p_mag   = p_sum[ssr_pkg::Q_FRAC +: QR_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_pab   <= P_W'(i_sums.sa) * P_W'(i_sums.sb);
                        r_paa   <= P_W'(i_sums.sa) * P_W'(i_sums.sa);
                        r_pbb   <= P_W'(i_sums.sb) * P_W'(i_sums.sb);
                        r_qab   <= Q_W'(i_n) * Q_W'(i_sums.sab);
                        r_qaa   <= Q_W'(i_n) * Q_W'(i_sums.saa);
                        r_qbb   <= Q_W'(i_n) * Q_W'(i_sums.sbb);
                        r_n2    <= N2_W'(i_n) * N2_W'(i_n);
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    r_cov <= $signed(COV_W'(r_qab)) - $signed(COV_W'(r_pab));
                    r_var <= $signed(VAR_W'(r_qaa)) - $signed(VAR_W'(r_paa))
                           + $signed(VAR_W'(r_qbb)) - $signed(VAR_W'(r_pbb));
                    r_lsq <= (P_W+1)'(r_paa) + (P_W+1)'(r_pbb);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_lnum <= L_W'(r_pab) * L_W'(ssr_pkg::LUM_K) + L_W'(r_n2);
                    r_lden <= L_W'(r_lsq) * L_W'(ssr_pkg::VAR_K) + L_W'(r_n2);
                    r_snum <= SN_W'(r_cov) * $signed(SN_W'(ssr_pkg::LUM_K))
                            + $signed(SN_W'(n2x9));
                    r_sden <= SD_W'(v_pos) * SD_W'(ssr_pkg::VAR_K) + SD_W'(n2x9);
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_neg   <= s_neg;
                    r_smag  <= s_clamp;
                    r_dr    <= (D_W+1)'(r_lnum);
                    r_dd    <= D_W'(r_lden);
                    r_cnt   <= '0;
                    r_phase <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dr  <= d_rem;
                    r_dq  <= d_q;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(QS_W - 1)) begin
                        r_cnt <= '0;
                        if (!r_phase) begin
                            // luminance done, start structure term
                            r_lum   <= d_rnd[QR_W:1];
                            r_dr    <= (D_W+1)'(r_smag);
                            r_dd    <= D_W'(r_sden);
                            r_phase <= 1'b1;
                        end else begin
                            r_st    <= d_rnd[QR_W:1];
                            r_state <= S_PROD;
                        end
                    end
                end
                S_PROD: begin
                    r_prod  <= PR_W'(r_lum) * PR_W'(r_st);
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_res   <= r_neg ? -$signed(ssr_pkg::RES_W'(p_mag))
                                     : $signed(ssr_pkg::RES_W'(p_mag));
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

/* design/windowed_ssim_rgb_core.sv */
// Windowed SSIM of two RGB images. Pixel pairs enter in raster order; per channel the block
// sums a, b, a*a, b*b and a*b for each window column in a one-port sum memory (one row of
// three channels per window column), read at acceptance and written back in the next cycle.
// One pixel is taken at a time. At each completed window the shared SSIM unit runs the
// three channels one after another (two 32-step fraction divisions each) while the input
// stalls. After the last pixel, if a window completed, four long divisions of ACC_W+1 steps
// each (53 at default size) form the channel means and their average; the result is held in
// an output register. A width, height or window write restarts the image. The sum memory
// needs no clearing: each entry is rewritten at the first pixel of its window.
`default_nettype none
module windowed_ssim_rgb_core #(
    parameter int MAX_WIDTH  = ssr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ssr_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WINDOW = ssr_pkg::MAX_WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_red_a,
    input  logic [7:0]         i_green_a,
    input  logic [7:0]         i_blue_a,
    input  logic [7:0]         i_red_b,
    input  logic [7:0]         i_green_b,
    input  logic [7:0]         i_blue_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_ssim_red,
    output logic signed [31:0] o_ssim_green,
    output logic signed [31:0] o_ssim_blue,
    output logic signed [31:0] o_ssim_mean,
    output logic               o_no_window,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [10:0]        i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WIN_W = $clog2(MAX_WINDOW);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int WE_W  = $clog2(MAX_WINDOW + 1);
    localparam int N_W   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int ACC_W = CNT_W + 31;
    localparam int NUM_W = ACC_W + 1;
    localparam int DEN_W = CNT_W + 1;
    localparam int TOT_W = 34;
    localparam int RW    = ssr_pkg::RES_W;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;
    localparam logic [1:0] FCH_MEAN   = 2'd3;

    typedef ssr_pkg::t_sums [2:0] t_row;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_WSTART,
        S_WWAIT,
        S_FSTART,
        S_FDIV,
        S_FWAIT,
        S_LOAD
    } t_state;

    t_state                   r_state;
    logic [10:0]              r_width, r_height;
    logic [4:0]               r_wsize;
    logic [COL_W-1:0]         r_col, r_idx;
    logic [WIN_W-1:0]         r_inc, r_riw;
    logic [ROW_W-1:0]         r_row;
    logic [CNT_W-1:0]         r_wcnt;
    logic signed [ACC_W-1:0]  r_acc [3];
    logic signed [RW-1:0]     r_chv [3];
    logic signed [RW-1:0]     r_fmean;
    logic [1:0]               r_wch, r_fch;
    logic                     r_last, r_nowin;
    logic [7:0]               r_pa [3];
    logic [7:0]               r_pb [3];
    logic [N_W-1:0]           r_n;
    t_row                     r_mem [MAX_WIDTH];
    t_row                     r_rdata, r_new;
    logic                     r_ovalid, r_onowin;
    logic signed [RW-1:0]     r_ored, r_ogreen, r_oblue, r_omean;

    logic [WD_W-1:0]          wd_eff;
    logic [HT_W-1:0]          ht_eff;
    logic [WE_W-1:0]          w_eff;
    logic                     col_more, row_more, inc_end, riw_end, first, done;
    t_row                     n_row;
    ssr_pkg::t_sums           base;
    logic                     accept;

    logic                     win_done;
    logic signed [RW-1:0]     win_res;

    logic                     f_neg;
    logic [ACC_W-1:0]         f_mag;
    logic [DEN_W-1:0]         f_half;
    logic [NUM_W-1:0]         f_num;
    logic [DEN_W-1:0]         f_den;
    logic signed [TOT_W-1:0]  f_tot;
    logic signed [RW-1:0]     f_res;
    logic                     div_done;
    logic [NUM_W-1:0]         div_quot;

    // saturate the configured sizes into their legal ranges
    always_comb begin
        if (r_width == '0) begin
            wd_eff = WD_W'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            wd_eff = WD_W'(MAX_WIDTH);
        end else begin
            wd_eff = WD_W'(r_width);
        end
        if (r_height == '0) begin
            ht_eff = HT_W'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            ht_eff = HT_W'(MAX_HEIGHT);
        end else begin
            ht_eff = HT_W'(r_height);
        end
        if (r_wsize == '0) begin
            w_eff = WE_W'(1);
        end else if (32'(r_wsize) > 32'(MAX_WINDOW)) begin
            w_eff = WE_W'(MAX_WINDOW);
        end else begin
            w_eff = WE_W'(r_wsize);
        end
    end

    always_comb begin
        col_more = (WD_W'(r_col) + WD_W'(1)) < wd_eff;
        row_more = (HT_W'(r_row) + HT_W'(1)) < ht_eff;
        inc_end  = (WE_W'(r_inc) == w_eff - WE_W'(1));
        riw_end  = (WE_W'(r_riw) == w_eff - WE_W'(1));
        first    = (r_riw == '0) && (r_inc == '0);
        done     = riw_end && inc_end;
        accept   = i_valid && o_ready;
    end

    always_comb begin
        n_row = '0;
        base  = '0;
        for (int c = 0; c < 3; c++) begin
            base = first ? '0 : r_rdata[c];
            n_row[c].sa  = base.sa + ssr_pkg::SUM_W'(r_pa[c]);
            n_row[c].sb  = base.sb + ssr_pkg::SUM_W'(r_pb[c]);
            n_row[c].saa = base.saa + ssr_pkg::SQ_W'(16'(r_pa[c]) * 16'(r_pa[c]));
            n_row[c].sbb = base.sbb + ssr_pkg::SQ_W'(16'(r_pb[c]) * 16'(r_pb[c]));
            n_row[c].sab = base.sab + ssr_pkg::SQ_W'(16'(r_pa[c]) * 16'(r_pb[c]));
        end
    end

    // sum memory: read every cycle at the current window column, write back in the update cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_idx];
        if (r_state == S_UPD) begin
            r_mem[r_idx] <= n_row;
            r_new        <= n_row;
        end
        if (accept) begin
            r_pa[0] <= i_red_a;
            r_pa[1] <= i_green_a;
            r_pa[2] <= i_blue_a;
            r_pb[0] <= i_red_b;
            r_pb[1] <= i_green_b;
            r_pb[2] <= i_blue_b;
        end
        r_n <= N_W'(w_eff) * N_W'(w_eff);
    end

    ssr_win #(
        .N_W (N_W)
    ) u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_WSTART),
        .i_n     (r_n),
        .i_sums  (r_new[r_wch]),
        .o_done  (win_done),
        .o_res   (win_res)
    );

    // operands of the final rounding divisions
    always_comb begin
        f_tot = TOT_W'(r_chv[0]) + TOT_W'(r_chv[1]) + TOT_W'(r_chv[2]);
        case (r_fch)
            2'd0, 2'd1, 2'd2: begin
                f_neg  = r_acc[r_fch][ACC_W-1];
                f_mag  = f_neg ? ACC_W'(-r_acc[r_fch]) : ACC_W'(r_acc[r_fch]);
                f_half = DEN_W'(r_wcnt);
                f_den  = DEN_W'({r_wcnt, 1'b0});
            end
            default: begin
                f_neg  = f_tot[TOT_W-1];
                f_mag  = f_neg ? ACC_W'(-f_tot) : ACC_W'(f_tot);
                f_half = DEN_W'(3);
                f_den  = DEN_W'(6);
            end
        endcase
        f_num = NUM_W'({f_mag, 1'b0}) + NUM_W'(f_half);
        f_res = f_neg ? -$signed(div_quot[RW-1:0]) : $signed(div_quot[RW-1:0]);
    end

    ssr_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_FDIV),
        .i_num   (f_num),
        .i_den   (f_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= 11'd256;
            r_height <= 11'd256;
            r_wsize  <= 5'd8;
            r_col    <= '0;
            r_idx    <= '0;
            r_inc    <= '0;
            r_riw    <= '0;
            r_row    <= '0;
            r_wcnt   <= '0;
            r_wch    <= '0;
            r_fch    <= '0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= '0;
            end
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_last <= !col_more && !row_more;
                    if (col_more) begin
                        r_col <= r_col + COL_W'(1);
                        if (inc_end) begin
                            r_inc <= '0;
                            r_idx <= r_idx + COL_W'(1);
                        end else begin
                            r_inc <= r_inc + WIN_W'(1);
                        end
                    end else begin
                        r_col <= '0;
                        r_inc <= '0;
                        r_idx <= '0;
                        if (row_more) begin
                            r_row <= r_row + ROW_W'(1);
                            r_riw <= riw_end ? '0 : r_riw + WIN_W'(1);
                        end else begin
                            r_row <= '0;
                            r_riw <= '0;
                        end
                    end
                    if (done) begin
                        r_wch   <= '0;
                        r_state <= S_WSTART;
                    end else if (!col_more && !row_more) begin
                        r_state <= S_FSTART;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_WSTART: begin
                    r_state <= S_WWAIT;
                end
                S_WWAIT: begin
                    if (win_done) begin
                        r_acc[r_wch] <= r_acc[r_wch] + ACC_W'(win_res);
                        if (r_wch == 2'd2) begin
                            r_wcnt  <= r_wcnt + CNT_W'(1);
                            r_state <= r_last ? S_FSTART : S_IDLE;
                        end else begin
                            r_wch   <= r_wch + 2'd1;
                            r_state <= S_WSTART;
                        end
                    end
                end
                S_FSTART: begin
                    r_fch   <= '0;
                    r_nowin <= (r_wcnt == '0);
                    r_state <= (r_wcnt == '0) ? S_LOAD : S_FDIV;
                end
                S_FDIV: begin
                    r_state <= S_FWAIT;
                end
                S_FWAIT: begin
                    if (div_done) begin
                        if (r_fch == FCH_MEAN) begin
                            r_fmean <= f_res;
                            r_state <= S_LOAD;
                        end else begin
                            r_chv[r_fch] <= f_res;
                            r_fch        <= r_fch + 2'd1;
                            r_state      <= S_FDIV;
                        end
                    end
                end
                S_LOAD: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_ready) begin
                        r_ovalid  <= 1'b1;
                        r_onowin  <= r_nowin;
                        r_ored    <= r_nowin ? '0 : r_chv[0];
                        r_ogreen  <= r_nowin ? '0 : r_chv[1];
                        r_oblue   <= r_nowin ? '0 : r_chv[2];
                        r_omean   <= r_nowin ? '0 : r_fmean;
                        r_wcnt <= '0;
                        for (int c = 0; c < 3; c++) begin
                            r_acc[c] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    REG_WINDOW: r_wsize  <= i_cfg_data[4:0];
                    default: ;
                endcase
                if (i_cfg_idx != FCH_MEAN) begin
                    // restart the image
                    r_col  <= '0;
                    r_idx  <= '0;
                    r_inc  <= '0;
                    r_riw  <= '0;
                    r_row  <= '0;
                    r_wcnt <= '0;
                    for (int c = 0; c < 3; c++) begin
                        r_acc[c] <= '0;
                    end
                end
            end
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_ssim_red   = r_ored;
    assign o_ssim_green = r_ogreen;
    assign o_ssim_blue  = r_oblue;
    assign o_ssim_mean  = r_omean;
    assign o_no_window  = r_onowin;

endmodule
`default_nettype wire

/* tb/windowed_ssim_rgb_core_tb.sv */
`timescale 1ns / 1ps
module windowed_ssim_rgb_core_tb;

    typedef enum logic [1:0] {REG_WIDTH, REG_HEIGHT, REG_WINDOW, REG_UNUSED} reg_idx_t;
    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct packed {
        logic signed [31:0] red;
        logic signed [31:0] green;
        logic signed [31:0] blue;
        logic signed [31:0] mean;
        logic               no_win;
    } ssim_res_t;

    typedef struct packed {
        row_kind_t   kind;
        reg_idx_t    idx;
        logic [10:0] data;
        logic [23:0] pix_a;
        logic [23:0] pix_b;
        logic        typed;
        ssim_res_t   res;
    } dir_row_t;

    localparam int  MAX_W       = ssr_pkg::MAX_WIDTH_DEF;
    localparam int  MAX_H       = ssr_pkg::MAX_HEIGHT_DEF;
    localparam int  MAX_WIN     = ssr_pkg::MAX_WINDOW_DEF;
    localparam int  SETTLE      = 600;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  ITEM_GOAL   = 1600;
    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_red_a = '0, i_green_a = '0, i_blue_a = '0;
    logic [7:0]  i_red_b = '0, i_green_b = '0, i_blue_b = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [31:0] o_ssim_red, o_ssim_green, o_ssim_blue, o_ssim_mean;
    logic        o_no_window;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [10:0] i_cfg_data = '0;

    windowed_ssim_rgb_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_red_a(i_red_a), .i_green_a(i_green_a), .i_blue_a(i_blue_a),
        .i_red_b(i_red_b), .i_green_b(i_green_b), .i_blue_b(i_blue_b),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_ssim_red(o_ssim_red), .o_ssim_green(o_ssim_green),
        .o_ssim_blue(o_ssim_blue), .o_ssim_mean(o_ssim_mean),
        .o_no_window(o_no_window),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // shadow of the block
    logic [10:0] reg_width, reg_height;
    logic [4:0]  reg_window;
    int unsigned col_sum_a [3][MAX_W];
    int unsigned col_sum_b [3][MAX_W];
    int unsigned col_sq_a  [3][MAX_W];
    int unsigned col_sq_b  [3][MAX_W];
    int unsigned col_cross [3][MAX_W];
    longint      ssim_acc [3];
    int unsigned win_count, col_pos, row_pos, band_row;

    ssim_res_t   pending_ssim[$];
    dir_row_t    dir_tab[$];
    int          fail_count = 0;
    int          item_count = 0;
    longint      cycle_count = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;

    function automatic int unsigned sat_reg(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // round(num * 2^30 / den), ties up
    function automatic longint unsigned frac_q30(longint unsigned num, longint unsigned den);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        for (int i = 0; i < 30; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        r = r << 1;
        if (r >= den) q = q + 1;
        return q;
    endfunction

    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint window_ssim(longint unsigned n, longint unsigned sa,
            longint unsigned sb, longint unsigned saa, longint unsigned sbb,
            longint unsigned sab);
        longint unsigned n2, lum_num, lum_den, st_den, st_mag, lum, prod;
        longint          cov, var_sum, st_num;
        bit              neg;
        n2 = n * n;
        lum_num = 20000 * sa * sb + n2;
        lum_den = 10000 * (sa * sa + sb * sb) + n2;
        cov = longint'(n * sab) - longint'(sa * sb);
        var_sum = longint'(n * saa) - longint'(sa * sa) + longint'(n * sbb) - longint'(sb * sb);
        st_num = 20000 * cov + 9 * longint'(n2);
        neg = st_num < 0;
        if (var_sum < 0) var_sum = 0;
        st_den = 10000 * longint'(var_sum) + 9 * n2;
        st_mag = neg ? longint'(-st_num) : st_num;
        if (st_mag > st_den) st_mag = st_den;
        lum = frac_q30(lum_num, lum_den);
        prod = lum * frac_q30(st_mag, st_den);
        prod = (prod + (64'd1 << 29)) >> 30;
        return neg ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic void restart_image();
        for (int c = 0; c < 3; c++) ssim_acc[c] = 0;
        win_count = 0;
        col_pos = 0;
        row_pos = 0;
        band_row = 0;
    endfunction

    function automatic void shadow_cfg(reg_idx_t idx, logic [10:0] data);
        case (idx)
            REG_WIDTH: reg_width = data;
            REG_HEIGHT: reg_height = data;
            REG_WINDOW: reg_window = data[4:0];
            default: return;
        endcase
        restart_image();
    endfunction

    // advance the shadow by one pixel pair; returns 1 when the image closes
    function automatic bit ssim_pixel(logic [23:0] pa, logic [23:0] pb, output ssim_res_t res);
        int unsigned wd, ht, w, idx, in_col, a, b;
        bit          first, done;
        longint      ch, total;
        wd = sat_reg(reg_width, MAX_W);
        ht = sat_reg(reg_height, MAX_H);
        w = sat_reg(reg_window, MAX_WIN);
        idx = col_pos / w;
        in_col = col_pos % w;
        first = (band_row == 0) && (in_col == 0);
        done = (band_row + 1 >= w) && (in_col == w - 1);
        if (idx >= MAX_W) idx = MAX_W - 1;
        res = '0;
        for (int c = 0; c < 3; c++) begin
            a = pa[23 - 8*c -: 8];
            b = pb[23 - 8*c -: 8];
            if (first) begin
                col_sum_a[c][idx] = 0;
                col_sum_b[c][idx] = 0;
                col_sq_a[c][idx] = 0;
                col_sq_b[c][idx] = 0;
                col_cross[c][idx] = 0;
            end
            col_sum_a[c][idx] = (col_sum_a[c][idx] + a) & 32'hFFFF;
            col_sum_b[c][idx] = (col_sum_b[c][idx] + b) & 32'hFFFF;
            col_sq_a[c][idx] = (col_sq_a[c][idx] + a * a) & 32'hFF_FFFF;
            col_sq_b[c][idx] = (col_sq_b[c][idx] + b * b) & 32'hFF_FFFF;
            col_cross[c][idx] = (col_cross[c][idx] + a * b) & 32'hFF_FFFF;
            if (done)
                ssim_acc[c] += window_ssim(w * w, col_sum_a[c][idx], col_sum_b[c][idx],
                    col_sq_a[c][idx], col_sq_b[c][idx], col_cross[c][idx]);
        end
        if (done) win_count++;
        if (col_pos + 1 < wd) begin
            col_pos++;
            return 0;
        end
        col_pos = 0;
        if (row_pos + 1 < ht) begin
            row_pos++;
            band_row = (band_row + 1 >= w) ? 0 : band_row + 1;
            return 0;
        end
        if (win_count == 0) begin
            res.no_win = 1'b1;
        end else begin
            total = 0;
            ch = round_div(ssim_acc[0], win_count);
            res.red = ch[31:0];
            total += ch;
            ch = round_div(ssim_acc[1], win_count);
            res.green = ch[31:0];
            total += ch;
            ch = round_div(ssim_acc[2], win_count);
            res.blue = ch[31:0];
            total += ch;
            ch = round_div(total, 3);
            res.mean = ch[31:0];
        end
        restart_image();
        return 1;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        fail_count++;
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // hold until drained and settled, then write one register
    task automatic write_reg(reg_idx_t idx, logic [10:0] data);
        i_valid <= 1'b0;
        wait (pending_ssim.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_cfg(idx, data);
    endtask

    task automatic send_pixel(logic [23:0] pa, logic [23:0] pb, bit typed, ssim_res_t want);
        int        gap;
        ssim_res_t res;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_red_a, i_green_a, i_blue_a} <= pa;
        {i_red_b, i_green_b, i_blue_b} <= pb;
        do @(posedge i_clk); while (!o_ready);
        item_count++;
        if (ssim_pixel(pa, pb, res)) pending_ssim.push_back(typed ? want : res);
    endtask

    function automatic void add_cfg(reg_idx_t idx, logic [10:0] data);
        dir_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.idx = idx;
        row.data = data;
        dir_tab.push_back(row);
    endfunction

    function automatic void add_pix(logic [23:0] pa, logic [23:0] pb, logic typed,
            ssim_res_t res);
        dir_row_t row;
        row = '0;
        row.kind = ROW_PIX;
        row.pix_a = pa;
        row.pix_b = pb;
        row.typed = typed;
        row.res = res;
        dir_tab.push_back(row);
    endfunction

    function automatic logic [7:0] related_byte(int mode, logic [7:0] a);
        case (mode)
            1: return a;
            2: return ~a;
            3: return a + 8'($urandom_range(0, 6)) - 8'd3;
            4: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        int r;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 8) stall_left <= $urandom_range(1, 4);
            else if (r < 10) stall_left <= $urandom_range(20, 150);
            i_ready <= (r >= 10);
        end
    end

    always @(posedge i_clk) begin
        ssim_res_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_ssim.size() == 0) begin
                $display("[%0t] result with nothing pending", $time);
                fail_count++;
            end else begin
                want = pending_ssim.pop_front();
                if (o_ssim_red !== want.red) report_mismatch("ssim_red", o_ssim_red, want.red);
                if (o_ssim_green !== want.green)
                    report_mismatch("ssim_green", o_ssim_green, want.green);
                if (o_ssim_blue !== want.blue)
                    report_mismatch("ssim_blue", o_ssim_blue, want.blue);
                if (o_ssim_mean !== want.mean)
                    report_mismatch("ssim_mean", o_ssim_mean, want.mean);
                if (o_no_window !== want.no_win)
                    report_mismatch("no_window", o_no_window, want.no_win);
            end
        end
    end

    initial begin
        ssim_res_t perfect, empty, none;
        ssim_res_t dummy;
        int        wd, ht, w, mode, images;
        logic [23:0] pa, pb;

        reg_width = 11'd256;
        reg_height = 11'd256;
        reg_window = 5'd8;
        for (int c = 0; c < 3; c++)
            for (int i = 0; i < MAX_W; i++) begin
                col_sum_a[c][i] = 0;
                col_sum_b[c][i] = 0;
                col_sq_a[c][i] = 0;
                col_sq_b[c][i] = 0;
                col_cross[c][i] = 0;
            end
        restart_image();

        perfect = '{red: Q30_ONE, green: Q30_ONE, blue: Q30_ONE, mean: Q30_ONE, no_win: 1'b0};
        empty = '{red: 0, green: 0, blue: 0, mean: 0, no_win: 1'b1};
        none = '0;

        // one-pixel images, saturation, no-fit, ignored index, full windows, partial edges
        add_cfg(REG_WIDTH, 11'd1);
        add_cfg(REG_HEIGHT, 11'd1);
        add_cfg(REG_WINDOW, 11'd1);
        add_pix(24'hFFFFFF, 24'hFFFFFF, 1'b1, perfect);
        add_cfg(REG_WINDOW, 11'd2);
        add_pix(24'h000000, 24'h000000, 1'b1, empty);
        add_cfg(REG_WIDTH, 11'd0);
        add_cfg(REG_HEIGHT, 11'd0);
        add_cfg(REG_WINDOW, 11'd0);
        add_pix(24'h000000, 24'h000000, 1'b1, perfect);
        add_cfg(REG_UNUSED, 11'h7FF);
        add_pix(24'hFF00FF, 24'h00FF00, 1'b0, none);
        add_cfg(REG_WIDTH, 11'd2);
        add_cfg(REG_HEIGHT, 11'd2);
        add_cfg(REG_WINDOW, 11'd2);
        add_pix(24'h00FF80, 24'hFF0080, 1'b0, none);
        add_pix(24'hFF007F, 24'h00FF7F, 1'b0, none);
        add_pix(24'hFF0001, 24'h00FF02, 1'b0, none);
        add_pix(24'h00FFFE, 24'hFF00FD, 1'b0, none);
        add_cfg(REG_WIDTH, 11'd3);
        add_cfg(REG_HEIGHT, 11'd3);
        for (int i = 0; i < 9; i++)
            add_pix(24'(24'h102030 * (i + 1)), 24'(24'h0F1F2F * (i + 2)), 1'b0, none);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        calm = 1'b1;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) write_reg(dir_tab[i].idx, dir_tab[i].data);
            else send_pixel(dir_tab[i].pix_a, dir_tab[i].pix_b, dir_tab[i].typed,
                            dir_tab[i].res);
        end

        // widest row, one-pixel windows
        calm = 1'b0;
        write_reg(REG_WIDTH, 11'h7FF);
        write_reg(REG_HEIGHT, 11'd1);
        write_reg(REG_WINDOW, 11'd1);
        for (int i = 0; i < MAX_W; i++)
            send_pixel(24'($urandom), 24'($urandom), 1'b0, dummy);

        while (item_count < ITEM_GOAL) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 99) < 4) begin
                w = 16;
                wd = $urandom_range(16, 18);
                ht = $urandom_range(16, 17);
            end else begin
                w = $urandom_range(0, 99) < 6 ? $urandom_range(17, 31) : $urandom_range(0, 5);
                wd = $urandom_range(0, 99) < 5 ? 0 : $urandom_range(1, 12);
                ht = $urandom_range(0, 99) < 5 ? 0 : $urandom_range(1, 12);
            end
            write_reg(REG_WINDOW, 11'(w));
            write_reg(REG_WIDTH, 11'(wd));
            write_reg(REG_HEIGHT, 11'(ht));
            if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, 11'($urandom));
            images = $urandom_range(1, 3);
            for (int k = 0; k < images; k++) begin
                mode = $urandom_range(0, 4);
                for (int i = 0; i < sat_reg(wd, MAX_W) * sat_reg(ht, MAX_H); i++) begin
                    pa = 24'($urandom);
                    if (mode == 4) pa = {related_byte(4, 0), related_byte(4, 0),
                                         related_byte(4, 0)};
                    pb = {related_byte(mode, pa[23:16]), related_byte(mode, pa[15:8]),
                          related_byte(mode, pa[7:0])};
                    send_pixel(pa, pb, 1'b0, dummy);
                end
            end
        end

        i_valid <= 1'b0;
        wait (pending_ssim.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
